/* design/pairwise_substitution_distance_assert.svh */
// ----------------------------------------------------------------------------
// Pairwise substitution distance: assertion macros
// Shared property forms; the using module provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_SUBSTITUTION_DISTANCE_ASSERT_SVH
`define PAIRWISE_SUBSTITUTION_DISTANCE_ASSERT_SVH

// condition holds at every edge out of reset
`define PSD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PSD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg
// Types, widths and constants shared by the distance controller and datapath.
// ----------------------------------------------------------------------------
package psd_pkg;

	localparam int CODE_W         = 8;
	localparam int CNT_W          = 17;
	localparam int DIST_W         = 32;
	localparam int MODEL_W        = 2;
	localparam int DIST_FRAC_BITS = 28;
	localparam int MAX_COLUMNS    = 65536;
	localparam int NUM_W          = CNT_W + 1;    // operands up to 3 * count
	localparam int LOGK_W         = 5;
	localparam int LOGF_W         = 32;
	localparam int LOG_W          = LOGK_W + LOGF_W;
	localparam int HI_W           = 51;
	localparam int LO_W           = 46;
	localparam int NL_W           = 38;
	localparam int ACC_W          = 40;
	localparam int QUO_W          = 30;
	localparam int RND_SH         = 32 - DIST_FRAC_BITS;
	localparam int STEP_W         = 6;
	localparam int DIV_STEPS      = 30;
	localparam int LOG_STEPS      = 32;

	localparam logic [29:0]         LN2_Q30  = 30'd744261118;
	localparam logic [DIST_W-1:0]   DIST_CAP = DIST_W'(3) << (DIST_FRAC_BITS - 1);

	localparam logic [MODEL_W-1:0]  MODEL_P   = 2'd0;
	localparam logic [MODEL_W-1:0]  MODEL_JC  = 2'd1;
	localparam logic [MODEL_W-1:0]  MODEL_K2P = 2'd2;

	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_SAT,
		KIND_DIV,
		KIND_LOG
	} dist_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_LOG_INIT,
		ST_LOG_SQ,
		ST_NL_HI,
		ST_NL_LO,
		ST_NL_ACC,
		ST_FINISH
	} psd_state_t;

	typedef struct packed {
		logic       count;
		logic       set_kind;
		dist_kind_t kind;
		logic       div_init;
		logic       div_step;
		logic       div_first;
		logic       log_init;
		logic       log_step;
		logic       log_store;
		logic       log_den;
		logic       pair;
		logic       nl_hi;
		logic       nl_lo;
		logic       nl_acc;
		logic       load_out;
	} psd_cmd_t;

	typedef struct packed {
		logic               no_data;
		logic               zero_diff;
		logic               jc_sat;
		logic               k2p_sat;
		logic [MODEL_W-1:0] model;
		logic               out_busy;
	} psd_sts_t;

	// index of the highest set bit
	function automatic logic [LOGK_W-1:0] msb_index(input logic [NUM_W-1:0] n);
		logic [LOGK_W-1:0] k;
		k = '0;
		for (int i = 0; i < NUM_W; i++) begin
			if (n[i]) begin
				k = LOGK_W'(i);
			end
		end
		return k;
	endfunction

endpackage

/* design/pairwise_substitution_distance.sv */
// ----------------------------------------------------------------------------
// pairwise_substitution_distance
// Pairwise p / JC69 / K2P distance over streamed alignment columns.
// ----------------------------------------------------------------------------
// Columns without last: one per cycle, counted as they are accepted.
// Last column: no data, no differences or saturated go straight to the
// result; p-distance runs a 30-step divider, JC69 and K2P run log2 steps
// on the one shared 32x32 multiplier. Input stalls until the result is loaded.
// Reset clears tallies, sequencer, output valid and selects p-distance.
module pairwise_substitution_distance
	import psd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [15:0]        s_tdata,   // code_a[7:0], code_b[15:8]
	input  logic               s_tuser,   // skip_column
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [87:0]        m_tdata,   // distance, comparable, transition,
	                                      // transversion counts, zero pad
	output logic [1:0]         m_tuser,   // saturated, no_data
	input  logic               cfg_wen,
	input  logic [MODEL_W-1:0] cfg_wdata
);

	psd_cmd_t          cmd;
	psd_sts_t          sts;
	logic [DIST_W-1:0] distance;
	logic [CNT_W-1:0]  comparable_count, transition_count, transversion_count;
	logic              saturated, no_data;

	psd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	psd_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.code_a             (s_tdata[7:0]),
		.code_b             (s_tdata[15:8]),
		.skip_column        (s_tuser),
		.cfg_wen            (cfg_wen),
		.cfg_wdata          (cfg_wdata),
		.out_ready          (m_tready),
		.out_valid          (m_tvalid),
		.distance           (distance),
		.comparable_count   (comparable_count),
		.transition_count   (transition_count),
		.transversion_count (transversion_count),
		.saturated          (saturated),
		.no_data            (no_data)
	);

	assign m_tdata = {5'b0, transversion_count, transition_count, comparable_count, distance};
	assign m_tuser = {no_data, saturated};

endmodule

/* design/psd_datapath.sv */
// ----------------------------------------------------------------------------
// psd_datapath
// Column tallies, shared multiplier, log2 squaring unit, divider, output word.
// ----------------------------------------------------------------------------
`include "pairwise_substitution_distance_assert.svh"

module psd_datapath
	import psd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  psd_cmd_t           cmd,
	output psd_sts_t           sts,
	input  logic [CODE_W-1:0]  code_a,
	input  logic [CODE_W-1:0]  code_b,
	input  logic               skip_column,
	input  logic               cfg_wen,
	input  logic [MODEL_W-1:0] cfg_wdata,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [DIST_W-1:0]  distance,
	output logic [CNT_W-1:0]   comparable_count,
	output logic [CNT_W-1:0]   transition_count,
	output logic [CNT_W-1:0]   transversion_count,
	output logic               saturated,
	output logic               no_data
);

	logic [MODEL_W-1:0] model_q;
	logic [CNT_W-1:0]   c_q, ti_q, tv_q;
	dist_kind_t         kind_q;
	logic [NUM_W-1:0]   r_q;
	logic [QUO_W-1:0]   quo_q;
	logic [31:0]        m_q;
	logic [LOGF_W-1:0]  frac_q;
	logic [LOGK_W-1:0]  k_q;
	logic [LOG_W-1:0]   ln_q, ld_q;
	logic [HI_W-1:0]    hi_q;
	logic [LO_W-1:0]    lo_q;
	logic [ACC_W-1:0]   acc_q;
	logic               out_valid_q;
	logic [DIST_W-1:0]  dist_q;
	logic [CNT_W-1:0]   oc_q, oti_q, otv_q;
	logic               osat_q, onod_q;

	logic               counted;
	logic [1:0]         diff;
	logic [NUM_W-1:0]   c18, d18, c3, jc_num, k0_num, k1_num, log_n;
	logic [LOGK_W-1:0]  log_k;
	logic [31:0]        m_init;
	logic [LOG_W-1:0]   l_diff;
	logic [31:0]        mul_a, mul_b;
	logic [63:0]        prod;
	logic [32:0]        sq;
	logic               sq_bit;
	logic [31:0]        m_next;
	logic [LOGF_W-1:0]  frac_next;
	logic [NL_W-1:0]    nl;
	logic [ACC_W-1:0]   nl_w;
	logic [NUM_W-1:0]   rr;
	logic               ge;
	logic [ACC_W-1:0]   log_rnd;
	logic [QUO_W-1:0]   div_q;
	logic [DIST_W-1:0]  dist_new;

	always_comb begin
		diff    = code_a[1:0] ^ code_b[1:0];
		counted = !skip_column && (code_a <= CODE_W'(3)) && (code_b <= CODE_W'(3))
			&& (c_q < CNT_W'(MAX_COLUMNS));
		c18     = {1'b0, c_q};
		d18     = {1'b0, ti_q} + {1'b0, tv_q};
		c3      = c18 + {c_q, 1'b0};
		jc_num  = c3 - {d18[NUM_W-3:0], 2'b00};
		k0_num  = c18 - {ti_q, 1'b0} - {1'b0, tv_q};
		k1_num  = c18 - {tv_q, 1'b0};
	end

	always_comb begin
		sts.no_data   = (c_q == '0);
		sts.zero_diff = (d18 == '0);
		sts.jc_sat    = ({d18, 2'b00} >= {2'b00, c3});
		sts.k2p_sat   = (({ti_q, 1'b0} + {1'b0, tv_q}) >= c18) || ({tv_q, 1'b0} >= c18);
		sts.model     = model_q;
		sts.out_busy  = out_valid_q && !out_ready;
	end

	// pick the log operand for this half of the pair
	always_comb begin
		if (cmd.log_den) begin
			log_n = (model_q == MODEL_JC) ? c3 : c18;
		end else if (model_q == MODEL_JC) begin
			log_n = jc_num;
		end else begin
			log_n = cmd.pair ? k1_num : k0_num;
		end
		log_k  = msb_index(log_n);
		m_init = 32'(log_n) << (LOGK_W'(31) - log_k);
	end

	always_comb begin
		l_diff = (ld_q > ln_q) ? (ld_q - ln_q) : '0;
		if (cmd.nl_hi) begin
			mul_a = 32'(l_diff[LOG_W-1:16]);
			mul_b = 32'(LN2_Q30);
		end else if (cmd.nl_lo) begin
			mul_a = 32'(l_diff[15:0]);
			mul_b = 32'(LN2_Q30);
		end else begin
			mul_a = m_q;
			mul_b = m_q;
		end
		prod      = 64'(mul_a) * 64'(mul_b);
		sq        = prod[63:31];
		sq_bit    = sq[32];
		m_next    = sq_bit ? sq[32:1] : sq[31:0];
		frac_next = {frac_q[LOGF_W-2:0], sq_bit};
	end

	always_comb begin
		nl = NL_W'(((HI_W+1)'(hi_q) + (HI_W+1)'(lo_q[LO_W-1:16])) >> 14);
		if (model_q == MODEL_JC) begin
			nl_w = ACC_W'(nl) + ACC_W'({nl, 1'b0});
		end else if (!cmd.pair) begin
			nl_w = ACC_W'({nl, 1'b0});
		end else begin
			nl_w = ACC_W'(nl);
		end
	end

	always_comb begin
		rr = cmd.div_first ? r_q : {r_q[NUM_W-2:0], 1'b0};
		ge = (rr >= c18);
	end

	always_comb begin
		log_rnd = ((acc_q >> 2) + ACC_W'(1 << (RND_SH - 1))) >> RND_SH;
		div_q   = (quo_q >> 1) + QUO_W'(quo_q[0]);
		case (kind_q)
			KIND_SAT: dist_new = DIST_CAP;
			KIND_DIV: dist_new = DIST_W'(div_q);
			KIND_LOG: dist_new = (log_rnd[ACC_W-1:DIST_W] != '0) ? '1 : log_rnd[DIST_W-1:0];
			default:  dist_new = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q     <= MODEL_P;
			c_q         <= '0;
			ti_q        <= '0;
			tv_q        <= '0;
			kind_q      <= KIND_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				model_q <= cfg_wdata;
			end
			if (cmd.count && counted) begin
				c_q <= c_q + 1'b1;
				if (diff == 2'd2) begin
					ti_q <= ti_q + 1'b1;
				end else if (diff != 2'd0) begin
					tv_q <= tv_q + 1'b1;
				end
			end
			if (cmd.set_kind) begin
				kind_q <= cmd.kind;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
				c_q         <= '0;
				ti_q        <= '0;
				tv_q        <= '0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_kind) begin
			acc_q <= '0;
		end
		if (cmd.div_init) begin
			r_q   <= d18;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			r_q   <= ge ? (rr - c18) : rr;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
		if (cmd.log_init) begin
			m_q    <= m_init;
			k_q    <= log_k;
			frac_q <= '0;
		end
		if (cmd.log_step) begin
			m_q    <= m_next;
			frac_q <= frac_next;
		end
		if (cmd.log_store) begin
			if (cmd.log_den) begin
				ld_q <= {k_q, frac_next};
			end else begin
				ln_q <= {k_q, frac_next};
			end
		end
		if (cmd.nl_hi) begin
			hi_q <= prod[HI_W-1:0];
		end
		if (cmd.nl_lo) begin
			lo_q <= prod[LO_W-1:0];
		end
		if (cmd.nl_acc) begin
			acc_q <= acc_q + nl_w;
		end
		if (cmd.load_out) begin
			dist_q <= dist_new;
			oc_q   <= c_q;
			oti_q  <= ti_q;
			otv_q  <= tv_q;
			osat_q <= (kind_q == KIND_SAT);
			onod_q <= (c_q == '0);
		end
	end

	assign out_valid          = out_valid_q;
	assign distance           = dist_q;
	assign comparable_count   = oc_q;
	assign transition_count   = oti_q;
	assign transversion_count = otv_q;
	assign saturated          = osat_q;
	assign no_data            = onod_q;

	`PSD_ASSERT_ALWAYS(a_tally_bound, (({1'b0, ti_q} + {1'b0, tv_q}) <= {1'b0, c_q}), "split tallies exceed comparable count")
	`PSD_ASSERT_IMPL(a_sat_cap, (out_valid_q && osat_q), (dist_q == DIST_CAP), "saturated word without cap distance")
	`PSD_ASSERT_IMPL(a_nodata_zero, (out_valid_q && onod_q), ((dist_q == '0) && !osat_q), "empty pair with nonzero distance")

endmodule

/* design/psd_ctrl.sv */
// ----------------------------------------------------------------------------
// psd_ctrl
// Sequencer: column intake, then divider or log/ln steps if needed, then result load.
// ----------------------------------------------------------------------------
module psd_ctrl
	import psd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_last,
	output logic     in_ready,
	input  psd_sts_t sts,
	output psd_cmd_t cmd
);

	psd_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              den_q, pair_q;
	logic              accept, step_end;

	assign accept = in_valid && in_ready;

	always_comb begin
		step_end = 1'b0;
		case (state_q)
			ST_DIV:    step_end = (step_q == STEP_W'(DIV_STEPS - 1));
			ST_LOG_SQ: step_end = (step_q == STEP_W'(LOG_STEPS - 1));
			default:   step_end = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_last) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.no_data || sts.zero_diff) begin
					state_d = ST_FINISH;
				end else if (sts.model == MODEL_JC) begin
					state_d = sts.jc_sat ? ST_FINISH : ST_LOG_INIT;
				end else if (sts.model == MODEL_K2P) begin
					state_d = sts.k2p_sat ? ST_FINISH : ST_LOG_INIT;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_LOG_INIT: state_d = ST_LOG_SQ;
			ST_LOG_SQ: begin
				if (step_end) begin
					state_d = den_q ? ST_NL_HI : ST_LOG_INIT;
				end
			end
			ST_NL_HI: state_d = ST_NL_LO;
			ST_NL_LO: state_d = ST_NL_ACC;
			ST_NL_ACC: begin
				state_d = (sts.model == MODEL_K2P && !pair_q) ? ST_LOG_INIT : ST_FINISH;
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		cmd           = '0;
		cmd.kind      = KIND_ZERO;
		cmd.count     = accept;
		cmd.log_den   = den_q;
		cmd.pair      = pair_q;
		cmd.div_first = (step_q == '0);
		case (state_q)
			ST_EVAL: begin
				cmd.set_kind = 1'b1;
				cmd.div_init = 1'b1;
				if (sts.no_data || sts.zero_diff) begin
					cmd.kind = KIND_ZERO;
				end else if (sts.model == MODEL_JC) begin
					cmd.kind = sts.jc_sat ? KIND_SAT : KIND_LOG;
				end else if (sts.model == MODEL_K2P) begin
					cmd.kind = sts.k2p_sat ? KIND_SAT : KIND_LOG;
				end else begin
					cmd.kind = KIND_DIV;
				end
			end
			ST_DIV:      cmd.div_step = 1'b1;
			ST_LOG_INIT: cmd.log_init = 1'b1;
			ST_LOG_SQ: begin
				cmd.log_step  = 1'b1;
				cmd.log_store = step_end;
			end
			ST_NL_HI:  cmd.nl_hi = 1'b1;
			ST_NL_LO:  cmd.nl_lo = 1'b1;
			ST_NL_ACC: cmd.nl_acc = 1'b1;
			ST_FINISH: cmd.load_out = !sts.out_busy;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			den_q   <= 1'b0;
			pair_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_DIV || state_q == ST_LOG_SQ) && !step_end) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			case (state_q)
				ST_EVAL: begin
					den_q  <= 1'b0;
					pair_q <= 1'b0;
				end
				ST_LOG_SQ: begin
					if (step_end) begin
						den_q <= !den_q;
					end
				end
				ST_NL_ACC: pair_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

endmodule

/* tb/tb_pairwise_substitution_distance.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pairwise_substitution_distance
// Streams alignment columns through the distance block under each model,
// predicts counts and distance per pair, and compares every result word.
// ----------------------------------------------------------------------------
module tb_pairwise_substitution_distance;
	import psd_pkg::*;

	typedef struct packed {
		logic [7:0] code_a;
		logic [7:0] code_b;
		logic       skip;
		logic       last;
	} column_t;

	typedef struct packed {
		logic [31:0] distance;
		logic [16:0] comparable;
		logic [16:0] transitions;
		logic [16:0] transversions;
		logic        saturated;
		logic        no_data;
	} pair_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_wen;
	logic [MODEL_W-1:0] cfg_wdata;

	column_t      pending_columns[$];
	pair_result_t expected_pairs[$];
	int           error_count;
	int           burst_left;
	int           gap_left;
	int           hold_off;
	logic         long_hold;

	logic [1:0]  model_sel;
	logic [31:0] tally_comp;
	logic [31:0] tally_ts;
	logic [31:0] tally_tv;

	pairwise_substitution_distance dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [63:0] log2_frac32(input logic [63:0] n);
		int unsigned e;
		logic [63:0] mant;
		logic [127:0] sq;
		logic [63:0] fr;
		e = 0;
		fr = 0;
		if (n == 0) return 0;
		while (e < 63 && (n >> (e + 1)) != 0) e++;
		mant = (e <= 31) ? n << (31 - e) : n >> (e - 31);
		for (int i = 0; i < 32; i++) begin
			sq = mant * mant;
			mant = sq[63:0] >> 31;
			fr = fr << 1;
			if (mant >= 64'h1_0000_0000) begin
				mant = mant >> 1;
				fr[0] = 1'b1;
			end
		end
		return (64'(e) << 32) | fr;
	endfunction

	function automatic logic [63:0] neg_ln(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] ln_n, ln_d, l, hi, lo;
		ln_n = log2_frac32(num);
		ln_d = log2_frac32(den);
		if (ln_n >= ln_d) return 0;
		l = ln_d - ln_n;
		hi = (l >> 16) * 64'd744261118;
		lo = (l & 64'hFFFF) * 64'd744261118;
		return (hi + (lo >> 16)) >> 14;
	endfunction

	function automatic logic [63:0] round_to_out(input logic [63:0] x);
		return (x + (64'd1 << (31 - DIST_FRAC_BITS))) >> (32 - DIST_FRAC_BITS);
	endfunction

	function automatic logic [63:0] ratio_rounded(input logic [63:0] num,
			input logic [63:0] den);
		logic [63:0] q, r;
		q = num / den;
		r = num % den;
		for (int i = 0; i < DIST_FRAC_BITS; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		if ((r << 1) >= den) q++;
		return q;
	endfunction

	// update tallies for one column; return 1 with the pair result on last
	function automatic bit predict_column(input column_t col, output pair_result_t res);
		logic [63:0] c, ti, tv, d, dist_val, ns, nv;
		res = '0;
		if (!col.skip && col.code_a <= 3 && col.code_b <= 3 && tally_comp < MAX_COLUMNS) begin
			tally_comp++;
			if (col.code_a != col.code_b) begin
				if ((col.code_a ^ col.code_b) == 8'd2) tally_ts++;
				else tally_tv++;
			end
		end
		if (!col.last) return 0;
		c = tally_comp;
		ti = tally_ts;
		tv = tally_tv;
		d = ti + tv;
		dist_val = 0;
		if (c != 0 && d != 0) begin
			if (model_sel == MODEL_JC) begin
				if (4 * d >= 3 * c) begin
					res.saturated = 1'b1;
					dist_val = DIST_CAP;
				end else begin
					dist_val = round_to_out((3 * neg_ln(3 * c - 4 * d, 3 * c)) >> 2);
				end
			end else if (model_sel == MODEL_K2P) begin
				if (2 * ti + tv >= c || 2 * tv >= c) begin
					res.saturated = 1'b1;
					dist_val = DIST_CAP;
				end else begin
					ns = neg_ln(c - 2 * ti - tv, c);
					nv = neg_ln(c - 2 * tv, c);
					dist_val = round_to_out((2 * ns + nv) >> 2);
				end
			end else begin
				dist_val = ratio_rounded(d, c);
			end
		end
		if (dist_val > 64'hFFFF_FFFF) dist_val = 64'hFFFF_FFFF;
		res.distance = dist_val[31:0];
		res.comparable = c[16:0];
		res.transitions = ti[16:0];
		res.transversions = tv[16:0];
		res.no_data = (c == 0);
		tally_comp = 0;
		tally_ts = 0;
		tally_tv = 0;
		return 1;
	endfunction

	// driver: bursts with gaps
	always @(posedge clk or negedge arst_n) begin
		column_t col;
		pair_result_t res;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			s_tlast <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				col = pending_columns.pop_front();
				if (predict_column(col, res)) expected_pairs.push_back(res);
			end
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_columns.size() > (s_tvalid && s_tready ? 0 : 0)
						&& pending_columns.size() != 0) begin
					col = pending_columns[0];
					s_tvalid <= 1'b1;
					s_tdata <= {col.code_b, col.code_a};
					s_tuser <= col.skip;
					s_tlast <= col.last;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_off <= 0;
		end else if (long_hold && hold_off < 3000) begin
			hold_off <= hold_off + 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// monitor
	always @(posedge clk) begin
		pair_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[48:32], m_tdata[65:49], m_tdata[82:66],
				m_tuser[0], m_tuser[1]};
			if (expected_pairs.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				error_count++;
			end else begin
				want = expected_pairs.pop_front();
				if (got.distance !== want.distance)
					$display("%0t: distance exp %h act %h", $time, want.distance, got.distance);
				if (got.comparable !== want.comparable)
					$display("%0t: comparable exp %0d act %0d", $time,
						want.comparable, got.comparable);
				if (got.transitions !== want.transitions)
					$display("%0t: transitions exp %0d act %0d", $time,
						want.transitions, got.transitions);
				if (got.transversions !== want.transversions)
					$display("%0t: transversions exp %0d act %0d", $time,
						want.transversions, got.transversions);
				if (got.saturated !== want.saturated)
					$display("%0t: saturated exp %b act %b", $time, want.saturated,
						got.saturated);
				if (got.no_data !== want.no_data)
					$display("%0t: no_data exp %b act %b", $time, want.no_data, got.no_data);
				if (got !== want) error_count++;
			end
		end
	end

	task automatic add_column(input int a, input int b, input bit skip, input bit last);
		column_t col;
		col.code_a = 8'(a);
		col.code_b = 8'(b);
		col.skip = skip;
		col.last = last;
		pending_columns.push_back(col);
	endtask

	// mostly bases, sometimes gaps or ambiguity codes with any bit pattern
	function automatic int random_code(input int gap_pct);
		if ($urandom_range(0, 99) < gap_pct) return $urandom_range(4, 255);
		return $urandom_range(0, 3);
	endfunction

	task automatic add_random_pair(input int len);
		int gap_pct, diff_pct, a, b;
		gap_pct = $urandom_range(0, 30);
		diff_pct = $urandom_range(0, 90);
		for (int i = 0; i < len; i++) begin
			a = random_code(gap_pct);
			b = ($urandom_range(0, 99) < diff_pct) ? random_code(gap_pct) : a;
			add_column(a, b, $urandom_range(0, 15) == 0, i == len - 1);
		end
	endtask

	task automatic drain_and_set(input logic [1:0] m);
		while (pending_columns.size() != 0 || expected_pairs.size() != 0) @(posedge clk);
		repeat (160) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_wen <= 1'b0;
		model_sel = m;
	endtask

	initial begin
		logic [1:0] phase_models[5];
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		long_hold = 1'b0;
		error_count = 0;
		model_sel = MODEL_P;
		tally_comp = 0;
		tally_ts = 0;
		tally_tv = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: no data, zero diffs, transitions, transversions, gaps, skip, extremes
		add_column(255, 0, 0, 1);
		add_column(0, 0, 1, 1);
		add_column(3, 3, 0, 0); add_column(2, 2, 0, 1);
		add_column(0, 2, 0, 0); add_column(1, 3, 0, 0); add_column(0, 0, 0, 1);
		add_column(0, 1, 0, 0); add_column(2, 3, 0, 0); add_column(0, 3, 0, 0);
		add_column(0, 0, 0, 0); add_column(1, 1, 0, 0); add_column(4, 0, 0, 1);
		add_column(170, 85, 0, 0); add_column(1, 0, 0, 1);
		phase_models = '{MODEL_JC, MODEL_K2P, 2'd3, MODEL_P, MODEL_K2P};
		for (int ph = 0; ph < 5; ph++) begin
			drain_and_set(phase_models[ph]);
			add_column(0, 2, 0, 1);
			add_column(0, 0, 0, 0); add_column(0, 1, 0, 0); add_column(0, 0, 0, 0);
			add_column(0, 2, 0, 1);
			add_column(0, 0, 0, 0); add_column(1, 3, 0, 0); add_column(2, 2, 0, 1);
			for (int p = 0; p < 22; p++) add_random_pair($urandom_range(1, 30));
			if (ph == 1) begin
				long_hold = 1'b1;
				for (int p = 0; p < 10; p++) add_random_pair($urandom_range(1, 4));
			end
		end
		drain_and_set(MODEL_P);
		while (pending_columns.size() != 0 || expected_pairs.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
